@@ design/assert_macros.svh @@
// Assertion macros for the design files, used by k_nearest_neighbour_select.
// Needs no other file; include it inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checks that cond never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)

`endif

@@ design/knn_pkg.sv @@
// Package of the nearest-neighbor selector: field widths, register indexes,
// the k-count reset value and the control bundle of the sorting cells. Depends on nothing.
package knn_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned DIST_W  = 33;
  localparam int unsigned RANK_W  = 4;
  localparam int unsigned KCNT_W  = 5;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  localparam logic [1:0] REG_QUERY_X = 2'd0;
  localparam logic [1:0] REG_QUERY_Y = 2'd1;
  localparam logic [1:0] REG_K_COUNT = 2'd2;

  localparam logic [KCNT_W-1:0] K_COUNT_RST = 5'd1;

  typedef struct packed {
    logic clear;
    logic shift;
    logic insert;
  } knn_cell_ctl_t;

endpackage

@@ design/knn_dist.sv @@
// Three-stage squared-distance pipeline between a request and the query point.
// Depends on nothing outside this file.
module knn_dist #(
  parameter int unsigned CW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  logic [CW-1:0]   x_i,
  input  logic [CW-1:0]   y_i,
  input  logic            last_i,
  input  logic [CW-1:0]   qx_i,
  input  logic [CW-1:0]   qy_i,
  output logic            vld_o,
  output logic            ins_o,
  output logic            last_o,
  output logic [CW-1:0]   x_o,
  output logic [CW-1:0]   y_o,
  output logic [2*CW:0]   d_o
);

  logic [2:0]          vld_q;
  logic [2:0]          ins_q;
  logic [2:0]          last_q;
  logic [CW-1:0]       x1_q, y1_q, x2_q, y2_q, x3_q, y3_q;
  logic [CW-1:0]       dx_q, dy_q, dx_d, dy_d;
  logic [2*CW-1:0]     sqx_q, sqy_q;
  logic [2*CW:0]       d_q;

  assign dx_d = (x_i >= qx_i) ? (x_i - qx_i) : (qx_i - x_i);
  assign dy_d = (y_i >= qy_i) ? (y_i - qy_i) : (qy_i - y_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      ins_q  <= '0;
      last_q <= '0;
    end else begin
      vld_q  <= {vld_q[1:0], vld_i};
      ins_q  <= {ins_q[1:0], vld_i && !((x_i == qx_i) && (y_i == qy_i))};
      last_q <= {last_q[1:0], vld_i && last_i};
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    x1_q  <= x_i;
    y1_q  <= y_i;
    sqx_q <= dx_q * dx_q;
    sqy_q <= dy_q * dy_q;
    x2_q  <= x1_q;
    y2_q  <= y1_q;
    d_q   <= {1'b0, sqx_q} + {1'b0, sqy_q};
    x3_q  <= x2_q;
    y3_q  <= y2_q;
  end

  assign vld_o  = vld_q[2];
  assign ins_o  = ins_q[2];
  assign last_o = last_q[2];
  assign x_o    = x3_q;
  assign y_o    = y3_q;
  assign d_o    = d_q;

endmodule

@@ design/knn_cell.sv @@
// One slot of the sorted insertion chain: holds a neighbor and its distance.
// Depends on knn_pkg for the control bundle.
module knn_cell #(
  parameter int unsigned CW = 16,
  parameter int unsigned DW = 33
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  knn_pkg::knn_cell_ctl_t ctl_i,
  input  logic [DW-1:0]          cand_d_i,
  input  logic [CW-1:0]          cand_x_i,
  input  logic [CW-1:0]          cand_y_i,
  input  logic                   lft_ins_i,
  input  logic [DW-1:0]          lft_d_i,
  input  logic [CW-1:0]          lft_x_i,
  input  logic [CW-1:0]          lft_y_i,
  input  logic                   lft_full_i,
  input  logic [DW-1:0]          rgt_d_i,
  input  logic [CW-1:0]          rgt_x_i,
  input  logic [CW-1:0]          rgt_y_i,
  input  logic                   rgt_full_i,
  output logic                   ins_o,
  output logic [DW-1:0]          d_o,
  output logic [CW-1:0]          x_o,
  output logic [CW-1:0]          y_o,
  output logic                   full_o
);
  import knn_pkg::*;

  logic [DW-1:0] d_q, d_d;
  logic [CW-1:0] x_q, x_d, y_q, y_d;
  logic          full_q, full_d;

  // The candidate belongs here or before this slot.
  assign ins_o = !full_q || (cand_d_i < d_q);

  always_comb begin
    d_d    = d_q;
    x_d    = x_q;
    y_d    = y_q;
    full_d = full_q;
    priority if (ctl_i.clear) begin
      full_d = 1'b0;
    end else if (ctl_i.shift) begin
      d_d    = rgt_d_i;
      x_d    = rgt_x_i;
      y_d    = rgt_y_i;
      full_d = rgt_full_i;
    end else if (ctl_i.insert && ins_o && !lft_ins_i) begin
      d_d    = cand_d_i;
      x_d    = cand_x_i;
      y_d    = cand_y_i;
      full_d = 1'b1;
    end else if (ctl_i.insert && ins_o) begin
      d_d    = lft_d_i;
      x_d    = lft_x_i;
      y_d    = lft_y_i;
      full_d = lft_full_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q <= d_d;
    x_q <= x_d;
    y_q <= y_d;
  end

  assign d_o    = d_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign full_o = full_q;

endmodule

@@ design/k_nearest_neighbour_select.sv @@
// Channel   | Direction | Signals
// request   | in        | in_valid_i/in_ready_o, cand_x_i, cand_y_i, last_cand_i
// result    | out       | out_valid_o/out_ready_i, rank_o, nbr_*_o, last_out_o
// config    | in        | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One request is taken per cycle while in_ready_o is high; its distance goes
// via knn_dist to the cell chain; all slots compare and insert it at once.
// A request marked last closes the input until the k results have been loaded
// into the output register, one per cycle while the result side is ready.
// Reset empties every slot at once; there is no clearing pass.
// Depends on knn_pkg, knn_dist, knn_cell and assert_macros.svh.
module k_nearest_neighbour_select #(
  parameter int unsigned K_MAX      = 16,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [knn_pkg::COORD_W-1:0]     cand_x_i,
  input  logic [knn_pkg::COORD_W-1:0]     cand_y_i,
  input  logic                            last_cand_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [knn_pkg::RANK_W-1:0]      rank_o,
  output logic [knn_pkg::COORD_W-1:0]     nbr_x_o,
  output logic [knn_pkg::COORD_W-1:0]     nbr_y_o,
  output logic [knn_pkg::DIST_W-1:0]      nbr_dist_sq_o,
  output logic                            nbr_valid_o,
  output logic                            last_out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [knn_pkg::ADDR_W-1:0]      paddr,
  input  logic [knn_pkg::DATA_W-1:0]      pwdata,
  output logic [knn_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);
  import knn_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned CW = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int unsigned DW = 2 * CW + 1;

  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_WAIT = 3'b010,
    ST_EMIT = 3'b100
  } knn_state_e;

  knn_state_e state_q, state_d;

  logic [COORD_W-1:0] qx_q, qy_q;
  logic [KCNT_W-1:0]  kc_q, kc_eff, k_last, cnt_q;
  logic               cfg_wr;

  logic               dist_vld, dist_ins, dist_last;
  logic [CW-1:0]      dist_x, dist_y;
  logic [DW-1:0]      dist_d;

  knn_cell_ctl_t      ctl;
  logic               load, is_last;

  logic [K_MAX-1:0]   ins_vec, full_vec, full_inc;
  logic [DW-1:0]      cell_d [K_MAX+1];
  logic [CW-1:0]      cell_x [K_MAX+1];
  logic [CW-1:0]      cell_y [K_MAX+1];
  logic [K_MAX:0]     cell_full;

  logic                out_valid_q, nbr_valid_q, last_out_q;
  logic [RANK_W-1:0]   rank_q;
  logic [COORD_W-1:0]  nbr_x_q, nbr_y_q;
  logic [DIST_W-1:0]   nbr_d_q;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qx_q <= '0;
      qy_q <= '0;
      kc_q <= K_COUNT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_QUERY_X: qx_q <= pwdata[COORD_W-1:0];
        REG_QUERY_Y: qy_q <= pwdata[COORD_W-1:0];
        REG_K_COUNT: kc_q <= pwdata[KCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_QUERY_X: prdata = DATA_W'(qx_q);
      REG_QUERY_Y: prdata = DATA_W'(qy_q);
      REG_K_COUNT: prdata = DATA_W'(kc_q);
      default:     prdata = '0;
    endcase
  end

  assign kc_eff = (kc_q == '0) ? KCNT_W'(1) : kc_q;
  assign k_last = (kc_eff > K_MAX) ? KCNT_W'(K_MAX - 1) : (kc_eff - KCNT_W'(1));

  // Distance pipeline.
  assign in_ready_o = (state_q == ST_RUN);

  knn_dist #(
    .CW (CW)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (in_valid_i && in_ready_o),
    .x_i    (cand_x_i[CW-1:0]),
    .y_i    (cand_y_i[CW-1:0]),
    .last_i (last_cand_i),
    .qx_i   (qx_q[CW-1:0]),
    .qy_i   (qy_q[CW-1:0]),
    .vld_o  (dist_vld),
    .ins_o  (dist_ins),
    .last_o (dist_last),
    .x_o    (dist_x),
    .y_o    (dist_y),
    .d_o    (dist_d)
  );

  // Sorted insertion chain; slot 0 is the nearest.
  assign load    = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign is_last = (cnt_q == k_last);

  assign ctl.clear  = load && is_last;
  assign ctl.shift  = load && !is_last;
  assign ctl.insert = dist_vld && dist_ins;

  assign cell_d[K_MAX]    = '0;
  assign cell_x[K_MAX]    = '0;
  assign cell_y[K_MAX]    = '0;
  assign cell_full[K_MAX] = 1'b0;

  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    logic          lft_ins;
    logic [DW-1:0] lft_d;
    logic [CW-1:0] lft_x, lft_y;
    logic          lft_full;

    if (i == 0) begin : g_head
      assign lft_ins  = 1'b0;
      assign lft_d    = '0;
      assign lft_x    = '0;
      assign lft_y    = '0;
      assign lft_full = 1'b0;
    end else begin : g_body
      assign lft_ins  = ins_vec[i-1];
      assign lft_d    = cell_d[i-1];
      assign lft_x    = cell_x[i-1];
      assign lft_y    = cell_y[i-1];
      assign lft_full = cell_full[i-1];
    end

    knn_cell #(
      .CW (CW),
      .DW (DW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .cand_d_i   (dist_d),
      .cand_x_i   (dist_x),
      .cand_y_i   (dist_y),
      .lft_ins_i  (lft_ins),
      .lft_d_i    (lft_d),
      .lft_x_i    (lft_x),
      .lft_y_i    (lft_y),
      .lft_full_i (lft_full),
      .rgt_d_i    (cell_d[i+1]),
      .rgt_x_i    (cell_x[i+1]),
      .rgt_y_i    (cell_y[i+1]),
      .rgt_full_i (cell_full[i+1]),
      .ins_o      (ins_vec[i]),
      .d_o        (cell_d[i]),
      .x_o        (cell_x[i]),
      .y_o        (cell_y[i]),
      .full_o     (cell_full[i])
    );
  end

  assign full_vec = cell_full[K_MAX-1:0];
  assign full_inc = full_vec + 1'b1;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN: begin
        if (in_valid_i && last_cand_i) state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (dist_vld && dist_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (load && is_last) state_d = ST_RUN;
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        cnt_q       <= is_last ? '0 : cnt_q + KCNT_W'(1);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rank_q      <= cnt_q[RANK_W-1:0];
      nbr_valid_q <= cell_full[0];
      nbr_x_q     <= cell_full[0] ? COORD_W'(cell_x[0]) : '0;
      nbr_y_q     <= cell_full[0] ? COORD_W'(cell_y[0]) : '0;
      nbr_d_q     <= cell_full[0] ? DIST_W'(cell_d[0]) : '0;
      last_out_q  <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign rank_o        = rank_q;
  assign nbr_x_o       = nbr_x_q;
  assign nbr_y_o       = nbr_y_q;
  assign nbr_dist_sq_o = nbr_d_q;
  assign nbr_valid_o   = nbr_valid_q;
  assign last_out_o    = last_out_q;

  `ASSERT_CLK(a_last_only_draining, clk_i, rst_ni, (dist_vld && dist_last) |-> (state_q == ST_WAIT), "last distance outside drain")
  `ASSERT_NEVER(a_full_prefix, clk_i, rst_ni, (full_vec & full_inc) != '0, "full slots not contiguous")
  `ASSERT_CLK(a_rank_steps, clk_i, rst_ni, (out_valid_o && out_ready_i && !last_out_o) |=> (out_valid_o && (rank_o == $past(rank_o) + 4'd1)), "rank did not advance")
  `ASSERT_CLK(a_clear_after_emit, clk_i, rst_ni, ctl.clear |=> (full_vec == '0), "list not cleared after emit")

endmodule
